// ===== src/fir_pkg.sv =====
package fir_pkg;

  // Filter geometry.
  localparam int NUM_TAPS   = 8;
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int COEF_FRAC  = 14;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int SUM_W      = PROD_W + $clog2(NUM_TAPS);
  localparam int OUT_W      = 21;
  localparam int TAP_CNT_W  = 4;
  localparam int TAP_IDX_W  = $clog2(NUM_TAPS);

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int COEF_PER_REG = CFG_DATA_W / COEF_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_LOW  = 2'd0,
    CFG_COEF_HIGH = 2'd1,
    CFG_TAP_COUNT = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    OP_FILTER = 1'b0,
    OP_CLEAR  = 1'b1
  } op_e;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [SUM_W-1:0]    sum_t;

  // Controls broadcast to every tap cell.
  typedef struct packed {
    logic shift;    // a filter word was accepted, history moves one cell
    logic clear;    // a clear word was accepted, history goes to zero
    logic advance;  // the pipeline moves this cycle
  } cell_ctrl_t;

endpackage

// ===== src/fir_filter_direct_form_core.sv =====
// Direct-form FIR filter, eight taps, signed 16-bit samples, Q2.14 coefficients.
//
// Input channel: in_valid_i / in_stall_o with op_i and sample_i. A word with
// op_i = OP_FILTER pushes the sample into the history and yields one result;
// a word with op_i = OP_CLEAR zeroes the history and yields nothing.
// Output channel: out_valid_o / out_stall_i with filtered_o, the full
// precision sum of coefficient times delayed sample, shifted right by 14
// (rounding toward minus infinity).
// Configuration: cfg_valid_i / cfg_ready_o, index and 64-bit data. Index 0
// holds taps 0..3, index 1 taps 4..7, index 2 the tap count (0 acts as 1,
// above 8 acts as 8). Other indexes are ignored. cfg_ready_o is always high;
// write only while no filter word is in flight.
//
// One word is taken per cycle unless a result waits on a stalled receiver. A
// filter word passes the tap cells' product registers, then the adder tree's
// first-level, second-level and final sum registers, and then shows up on the
// output. The whole pipeline moves together, so while a result waits on a
// stalled receiver, in_stall_o is high and nothing moves. Reset clears the
// history, the coefficients and all valid flags, and sets the tap count to eight.
module fir_filter_direct_form_core
  import fir_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input words
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  op_i,
  input  logic signed [15:0]    sample_i,
  // result words
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [20:0]    filtered_o,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [CFG_DATA_W-1:0] coef_low_q, coef_high_q;
  logic [TAP_CNT_W-1:0]  tap_count_q;
  logic [TAP_CNT_W-1:0]  eff_taps;

  logic       advance;
  logic       in_accept;
  cell_ctrl_t cell_ctrl;

  sample_t hist     [NUM_TAPS];
  sample_t chain_in [NUM_TAPS];
  coef_t   coef     [NUM_TAPS];
  prod_t   product  [NUM_TAPS];
  logic [NUM_TAPS-1:0] tap_on;

  sum_t sum;

  // Configuration registers. The port never pushes back.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_low_q  <= '0;
      coef_high_q <= '0;
      tap_count_q <= TAP_CNT_W'(NUM_TAPS);
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_COEF_LOW:  coef_low_q  <= cfg_data_i;
        CFG_COEF_HIGH: coef_high_q <= cfg_data_i;
        CFG_TAP_COUNT: tap_count_q <= cfg_data_i[TAP_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Tap count saturates into the range one to eight.
  always_comb begin
    eff_taps = tap_count_q;
    if (tap_count_q == '0) begin
      eff_taps = TAP_CNT_W'(1);
    end else if (tap_count_q > TAP_CNT_W'(NUM_TAPS)) begin
      eff_taps = TAP_CNT_W'(NUM_TAPS);
    end
  end

  // The pipeline advances unless a finished result sits on a stalled output.
  assign advance    = !(out_valid_o && out_stall_i);
  assign in_stall_o = !advance;
  assign in_accept  = in_valid_i && advance;

  assign cell_ctrl.shift   = in_accept && (op_e'(op_i) == OP_FILTER);
  assign cell_ctrl.clear   = in_accept && (op_e'(op_i) == OP_CLEAR);
  assign cell_ctrl.advance = advance;

  // Row of tap cells; each takes its neighbor's sample on a shift.
  for (genvar k = 0; k < NUM_TAPS; k++) begin : g_tap
    if (k == 0) begin : g_head
      assign chain_in[k] = sample_i;
    end else begin : g_link
      assign chain_in[k] = hist[k-1];
    end

    if (k < COEF_PER_REG) begin : g_low
      assign coef[k] = coef_low_q[k*COEF_W +: COEF_W];
    end else begin : g_high
      assign coef[k] = coef_high_q[(k-COEF_PER_REG)*COEF_W +: COEF_W];
    end

    assign tap_on[k] = TAP_CNT_W'(k) < eff_taps;

    fir_tap_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (cell_ctrl),
      .sample_i  (chain_in[k]),
      .coef_i    (coef[k]),
      .tap_on_i  (tap_on[k]),
      .sample_o  (hist[k]),
      .product_o (product[k])
    );
  end

  fir_adder_tree u_tree (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .valid_i   (cell_ctrl.shift),
    .product_i (product),
    .valid_o   (out_valid_o),
    .sum_o     (sum)
  );

  // The sum cannot exceed 35 bits, so dropping the fraction bits always fits.
  assign filtered_o = sum[COEF_FRAC +: OUT_W];

  // A clear word leaves the newest history cell at zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_ctrl.clear |=> (hist[0] == '0))
    else $error("history not cleared after a clear word");

  // A filter word lands in the newest history cell.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_ctrl.shift |=> (hist[0] == $past(sample_i)))
    else $error("accepted sample missing from history");

  // Input backpressure only comes from a result waiting at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a waiting result");

  // The oldest history cell moves only on an accepted word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_accept |=> $stable(hist[NUM_TAPS-1]))
    else $error("history moved without an accepted word");

endmodule

// ===== src/fir_tap_cell.sv =====
module fir_tap_cell
  import fir_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  sample_t    sample_i,
  input  coef_t      coef_i,
  input  logic       tap_on_i,
  output sample_t    sample_o,
  output prod_t      product_o
);

  sample_t sample_q, sample_d;
  prod_t   product_q;
  prod_t   mult;

  // The product uses the sample this cell holds once the shift is done.
  assign mult = prod_t'(coef_i) * prod_t'(sample_i);

  always_comb begin
    sample_d = sample_q;
    if (ctrl_i.clear) begin
      sample_d = '0;
    end else if (ctrl_i.shift) begin
      sample_d = sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else begin
      sample_q <= sample_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance) begin
      product_q <= tap_on_i ? mult : '0;
    end
  end

  assign sample_o  = sample_q;
  assign product_o = product_q;

endmodule

// ===== src/fir_adder_tree.sv =====
module fir_adder_tree
  import fir_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  advance_i,
  input  logic  valid_i,
  input  prod_t product_i [NUM_TAPS],
  output logic  valid_o,
  output sum_t  sum_o
);

  localparam int L1_N = NUM_TAPS / 2;
  localparam int L2_N = NUM_TAPS / 4;
  localparam int L1_W = PROD_W + 1;
  localparam int L2_W = PROD_W + 2;

  logic signed [L1_W-1:0] l1_q [L1_N];
  logic signed [L2_W-1:0] l2_q [L2_N];
  sum_t                   sum_q;
  logic                   v1_q, v2_q, v3_q, v4_q;

  // One valid flag per register stage: products, two tree levels, final sum.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (advance_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      for (int i = 0; i < L1_N; i++) begin
        l1_q[i] <= L1_W'(product_i[2*i]) + L1_W'(product_i[2*i+1]);
      end
      for (int i = 0; i < L2_N; i++) begin
        l2_q[i] <= L2_W'(l1_q[2*i]) + L2_W'(l1_q[2*i+1]);
      end
      sum_q <= SUM_W'(l2_q[0]) + SUM_W'(l2_q[1]);
    end
  end

  assign valid_o = v4_q;
  assign sum_o   = sum_q;

endmodule
